// File: rtl/core/rmmst_pkg.sv
// Package: shared types and constants of the min/max range tree.
package rmmst_pkg;

	localparam int unsigned MODE_W  = 2;
	localparam int unsigned POS_W   = 17;
	localparam int unsigned FVAL_W  = 24;
	localparam int unsigned CNT_W   = 17;
	localparam logic [CNT_W-1:0] COUNT_RESET = 17'd65536;

	// tree size and stored value width, tied to the field widths above
	localparam int unsigned MAX_ELEMENTS = 65536;
	localparam int unsigned VALUE_BITS   = 24;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  position;
		logic [FVAL_W-1:0] value;
		logic [POS_W-1:0]  range_low;
		logic [POS_W-1:0]  range_high;
	} req_t;

	typedef struct packed {
		logic [FVAL_W-1:0] spread;
		logic              range_empty;
		logic              range_bad;
	} rsp_t;

endpackage

// File: rtl/core/rmmst_if.sv
// Interfaces: valid/ready channels for requests, results and configuration.
interface rmmst_req_if;
	logic valid;
	logic ready;
	rmmst_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface rmmst_rsp_if;
	logic valid;
	logic ready;
	rmmst_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface rmmst_cfg_if;
	logic valid;
	logic ready;
	logic [16:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/range_min_max_spread_tree_top.sv
// Top level: segment tree of min/max values with range spread queries.
//
//  channel  dir  payload                                     beat
//  req      in   mode, position, value, range_low, range_high one command
//  rsp      out  spread, range_empty, range_bad               one query result
//  cfg      in   element_count                                one register write
//
// Write: per tree level, ST_WRD reads the left child, ST_WLAT latches it and reads the right, ST_WUP writes the parent.
// Query: each node visit passes ST_QSEL then ST_QTAKE; a level has up to 2 visits, then
// one shift of both bounds to the parent level.
// Clear and reset sweep all 2*MAX_ELEMENTS node addresses, one per cycle;
// no request is taken during the sweep. One node memory port sets the pace.
// A finished result waits in its output register; the next request is taken
// in the cycle that the result leaves.
module range_min_max_spread_tree_top (
	input  logic clk,
	input  logic arst_n,
	rmmst_req_if.sink   req,
	rmmst_rsp_if.source rsp,
	rmmst_cfg_if.sink   cfg
);
	import rmmst_pkg::*;

	localparam int unsigned LW  = $clog2(MAX_ELEMENTS);
	localparam int unsigned AW  = LW + 1;
	localparam int unsigned NW  = AW + 1; // node index incl. end value
	localparam logic [VALUE_BITS-1:0] VAL_ONES = '1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLR   = 7'b0000010,
		ST_WRD   = 7'b0000100,
		ST_WLAT  = 7'b0001000,
		ST_WUP   = 7'b0010000,
		ST_QSEL  = 7'b0100000,
		ST_QTAKE = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;

	// node memory: {written, max, min}
	localparam int unsigned MW = 2*VALUE_BITS + 1;
	logic [MW-1:0] mem [0:2*MAX_ELEMENTS-1];
	logic [MW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	logic [AW-1:0] clr_q;
	logic [AW-1:0] node_q;
	logic [MW-1:0] left_q;
	logic [NW-1:0] l_q, r_q;
	logic          any_q;
	logic [VALUE_BITS-1:0] mn_q, mx_q;
	rsp_t          out_q;
	logic          out_v_q;
	logic          out_set;

	logic [POS_W:0]  in_use;
	logic            pos_ok, q_bad;
	logic [MW-1:0]   merged;

	assign in_use = (count_q < CNT_W'(MAX_ELEMENTS)) ? {1'b0, count_q} : (POS_W+1)'(MAX_ELEMENTS);
	assign pos_ok = (req.payload.position != '0) && ({1'b0, req.payload.position} <= in_use);
	assign q_bad  = (req.payload.range_low == '0) ||
		(req.payload.range_low > req.payload.range_high) ||
		({1'b0, req.payload.range_high} <= in_use ? 1'b0 : 1'b1);

	// merge left child (left_q) with right child (rd_q)
	always_comb begin
		logic w; logic [VALUE_BITS-1:0] mn, mx;
		w = 1'b0; mn = VAL_ONES; mx = '0;
		if (left_q[MW-1]) begin
			w = 1'b1; mn = left_q[VALUE_BITS-1:0]; mx = left_q[2*VALUE_BITS-1:VALUE_BITS];
		end
		if (rd_q[MW-1]) begin
			if (!w || rd_q[VALUE_BITS-1:0] < mn) mn = rd_q[VALUE_BITS-1:0];
			if (!w || rd_q[2*VALUE_BITS-1:VALUE_BITS] > mx) mx = rd_q[2*VALUE_BITS-1:VALUE_BITS];
			w = 1'b1;
		end
		merged = {w, mx, mn};
	end

	logic acc;
	assign acc     = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && (!out_v_q || rsp.ready);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_v_q;
	assign rsp.payload = out_q;

	assign out_set = (acc && req.payload.mode == MODE_QUERY && q_bad) ||
		(state_q == ST_QSEL && l_q >= r_q);

	// memory port steering
	always_comb begin
		rd_addr = node_q;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = merged;
		case (state_q)
			ST_CLR: begin
				wr_en = 1'b1; wr_addr = clr_q; wr_data = {1'b0, {VALUE_BITS{1'b0}}, VAL_ONES};
			end
			ST_WRD:  rd_addr = {node_q[AW-2:0], 1'b0};
			ST_WLAT: rd_addr = {node_q[AW-1:1], 1'b1};
			ST_WUP:  wr_en = 1'b1;
			// address the node to visit so its data is ready in ST_QTAKE
			ST_QSEL: rd_addr = l_q[0] ? l_q[AW-1:0] : AW'(r_q - NW'(1));
			ST_IDLE: if (acc && req.payload.mode == MODE_WRITE && pos_ok) begin
				wr_en = 1'b1;
				wr_addr = AW'(MAX_ELEMENTS) + AW'(req.payload.position) - AW'(1);
				wr_data = {1'b1, req.payload.value[VALUE_BITS-1:0],
					req.payload.value[VALUE_BITS-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			count_q <= COUNT_RESET;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg.valid) count_q <= cfg.payload;
			out_v_q <= out_set || (out_v_q && !rsp.ready);
			case (state_q)
				ST_IDLE: if (acc) begin
					case (req.payload.mode)
						MODE_WRITE: if (pos_ok) begin
							node_q  <= (AW'(MAX_ELEMENTS) + AW'(req.payload.position) - AW'(1)) >> 1;
							state_q <= ST_WRD;
						end
						MODE_CLEAR: begin clr_q <= '0; state_q <= ST_CLR; end
						MODE_QUERY: if (q_bad) begin
							out_q   <= '{spread: '0, range_empty: 1'b0, range_bad: 1'b1};
						end else begin
							l_q <= NW'(MAX_ELEMENTS) + NW'(req.payload.range_low) - NW'(1);
							r_q <= NW'(MAX_ELEMENTS) + NW'(req.payload.range_high);
							any_q <= 1'b0; mn_q <= '0; mx_q <= '0;
							state_q <= ST_QSEL;
						end
						default: ;
					endcase
				end
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(2*MAX_ELEMENTS-1)) state_q <= ST_IDLE;
				end
				ST_WRD: begin
					node_q  <= node_q << 1;
					state_q <= ST_WLAT;
				end
				ST_WLAT: begin
					left_q  <= rd_q;
					node_q  <= node_q >> 1;
					state_q <= ST_WUP;
				end
				ST_WUP: begin
					left_q <= '0;
					if (node_q == AW'(1)) state_q <= ST_IDLE;
					else begin node_q <= node_q >> 1; state_q <= ST_WRD; end
				end
				ST_QSEL: begin
					if (l_q >= r_q) begin
						out_q.spread      <= any_q ? FVAL_W'(mx_q - mn_q) : '0;
						out_q.range_empty <= !any_q;
						out_q.range_bad   <= 1'b0;
						state_q <= ST_IDLE;
					end else if (l_q[0]) begin
						l_q <= l_q + NW'(1); state_q <= ST_QTAKE;
					end else if (r_q[0]) begin
						r_q <= r_q - NW'(1); state_q <= ST_QTAKE;
					end else begin
						l_q <= l_q >> 1; r_q <= r_q >> 1;
					end
				end
				ST_QTAKE: begin
					if (rd_q[MW-1]) begin
						if (!any_q || rd_q[VALUE_BITS-1:0] < mn_q) mn_q <= rd_q[VALUE_BITS-1:0];
						if (!any_q || rd_q[2*VALUE_BITS-1:VALUE_BITS] > mx_q)
							mx_q <= rd_q[2*VALUE_BITS-1:VALUE_BITS];
						any_q <= 1'b1;
					end
					state_q <= ST_QSEL;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready) else $error("ready while busy");
	ap_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload))) else $error("rsp dropped");
	ap_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.payload.range_bad && rsp.payload.range_empty)) else $error("two flags");
	ap_spread0: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.payload.range_bad || rsp.payload.range_empty)) |->
		(rsp.payload.spread == '0)) else $error("flagged spread");
endmodule
